// ===== design/kvt_pkg.sv =====
package kvt_pkg;

    // Field widths
    localparam int ACT_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int HASH_W  = 32;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 9;

    // djb2 seed
    localparam logic [HASH_W-1:0] HASH_START = 32'd5381;

    // Defaults for the top-level parameters
    localparam int DEF_NUM_BUCKETS = 64;
    localparam int DEF_WAYS        = 4;

    // Depth of the queue between hashing and table update
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUT    = 2'd0,
        ACT_GET    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_REPLACED  = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_FULL_CLR  = 3'd5
    } t_status;

endpackage

// ===== design/kvt_ram.sv =====
module kvt_ram
    import kvt_pkg::*;
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/kvt_fifo.sv =====
module kvt_fifo
    import kvt_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             push_ok, pop_ok;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop_ok) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/kvt_front.sv =====
module kvt_front
    import kvt_pkg::*;
#(
    parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
    parameter int SLOT_W      = 6,
    parameter int CMD_W       = 72
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [BYTE_W-1:0] i_key_byte,
    input  logic              i_key_last,
    input  logic [VAL_W-1:0]  i_value,
    output logic              o_cmd_push,
    output logic [CMD_W-1:0]  o_cmd_data,
    input  logic              i_cmd_full
);

    localparam bit IS_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);

    // Steps of the bucket index calculation
    typedef enum logic [4:0] {
        P_IDLE = 5'b00001,
        P_FOLD = 5'b00010,
        P_QUOT = 5'b00100,
        P_REM  = 5'b01000,
        P_SEND = 5'b10000
    } t_step;

    logic [HASH_W-1:0] r_acc;
    logic [HASH_W-1:0] n_hash;

    // djb2 step: h * 33 + byte
    assign n_hash = (r_acc << 5) + r_acc + HASH_W'(i_key_byte);

    generate
        if (IS_POW2) begin : g_mask
            logic accept;

            assign o_full     = i_cmd_full;
            assign accept     = i_push && !o_full;
            assign o_cmd_push = accept && i_key_last;
            assign o_cmd_data = {i_action, n_hash,
                                 SLOT_W'(n_hash & HASH_W'(NUM_BUCKETS - 1)), i_value};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_acc <= HASH_START;
                end else if (accept) begin
                    r_acc <= i_key_last ? HASH_START : n_hash;
                end
            end
        end else begin : g_rem
            // Bucket index in three register steps: fold the hash bytes with their
            // weights mod NUM_BUCKETS, divide by reciprocal multiply, subtract
            localparam int FOLD_W = BYTE_W + SLOT_W + 2;
            localparam int MUL_W  = FOLD_W + 1;
            localparam int PROD_W = FOLD_W + MUL_W;
            localparam int W0     = 1 % NUM_BUCKETS;
            localparam int W1     = 256 % NUM_BUCKETS;
            localparam int W2     = 65536 % NUM_BUCKETS;
            localparam int W3     = 16777216 % NUM_BUCKETS;
            // ceil(2^(FOLD_W+SLOT_W) / NUM_BUCKETS): exact quotient for any fold value
            localparam longint unsigned RECIP =
                ((64'd1 << (FOLD_W + SLOT_W)) + 64'(NUM_BUCKETS) - 64'd1)
                / 64'(NUM_BUCKETS);

            logic              accept;
            t_step             r_step;
            logic [HASH_W-1:0] r_hash;
            logic [FOLD_W-1:0] r_fold, r_quot;
            logic [SLOT_W-1:0] r_rem;
            logic [ACT_W-1:0]  r_act;
            logic [VAL_W-1:0]  r_val;
            logic [FOLD_W-1:0] fold;
            logic [PROD_W-1:0] prod;
            logic [FOLD_W-1:0] qn;

            assign o_full     = (r_step != P_IDLE) || i_cmd_full;
            assign accept     = i_push && !o_full;
            assign o_cmd_push = (r_step == P_SEND) && !i_cmd_full;
            assign o_cmd_data = {r_act, r_hash, r_rem, r_val};

            // Byte weights are 256^i mod NUM_BUCKETS, so the sum keeps the remainder
            assign fold = FOLD_W'(r_hash[0 +: BYTE_W]) * FOLD_W'(W0)
                        + FOLD_W'(r_hash[8 +: BYTE_W]) * FOLD_W'(W1)
                        + FOLD_W'(r_hash[16 +: BYTE_W]) * FOLD_W'(W2)
                        + FOLD_W'(r_hash[24 +: BYTE_W]) * FOLD_W'(W3);
            assign prod = PROD_W'(r_fold) * PROD_W'(RECIP);
            assign qn   = r_quot * FOLD_W'(NUM_BUCKETS);

            always_ff @(posedge i_clk) begin
                if (accept && i_key_last) begin
                    r_hash <= n_hash;
                    r_act  <= i_action;
                    r_val  <= i_value;
                end
                case (r_step)
                    P_FOLD:  r_fold <= fold;
                    P_QUOT:  r_quot <= FOLD_W'(prod >> (FOLD_W + SLOT_W));
                    P_REM:   r_rem  <= SLOT_W'(r_fold - qn);
                    default: ;
                endcase
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_acc  <= HASH_START;
                    r_step <= P_IDLE;
                end else begin
                    if (accept) begin
                        r_acc <= i_key_last ? HASH_START : n_hash;
                    end
                    case (r_step)
                        P_IDLE:  if (accept && i_key_last) r_step <= P_FOLD;
                        P_FOLD:  r_step <= P_QUOT;
                        P_QUOT:  r_step <= P_REM;
                        P_REM:   r_step <= P_SEND;
                        P_SEND:  if (!i_cmd_full) r_step <= P_IDLE;
                        default: r_step <= P_IDLE;
                    endcase
                end
            end
        end
    endgenerate

endmodule

// ===== design/kvt_back.sv =====
module kvt_back
    import kvt_pkg::*;
#(
    parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
    parameter int WAYS        = DEF_WAYS,
    parameter int SLOT_W      = 6,
    parameter int CMD_W       = 72
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_empty,
    input  logic [CMD_W-1:0]   i_cmd_data,
    output logic               o_cmd_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [STAT_W-1:0]  o_status,
    output logic [VAL_W-1:0]   o_value_out,
    output logic [COUNT_W-1:0] o_entry_count
);

    localparam int ENT_W  = HASH_W + VAL_W;
    localparam int DATA_W = WAYS * ENT_W;
    localparam int ROW_W  = DATA_W + WAYS;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_CLR  = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [ACT_W-1:0]   r_act;
    logic [HASH_W-1:0]  r_hash;
    logic [SLOT_W-1:0]  r_bucket;
    logic [VAL_W-1:0]   r_val;
    logic [SLOT_W-1:0]  r_clr_idx;
    logic               r_clr_reply;
    logic [COUNT_W-1:0] r_count;
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_status;
    logic [VAL_W-1:0]   r_vout;

    logic [ROW_W-1:0]   row;
    logic [ROW_W-1:0]   wrow;
    logic               upd;
    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr;
    logic [ROW_W-1:0]   ram_wdata;
    logic [WAYS-1:0]    vrow;
    logic [WAYS-1:0]    n_vrow;
    logic               hit, has_free;
    logic [WAY_W-1:0]   hit_way, free_way;
    logic               issue;
    logic               is_clear_cmd;
    logic               clr_last;
    logic [STAT_W-1:0]  n_status;
    logic [VAL_W-1:0]   n_vout;
    logic [COUNT_W-1:0] n_count;

    // Bucket rows: valid bits on top, then hash and value of every way
    kvt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_BUCKETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (i_cmd_data[VAL_W +: SLOT_W]),
        .o_rdata (row)
    );

    // Start when the output register is free at the end of the action
    assign issue        = (r_state == S_IDLE) && !i_cmd_empty && (!r_out_valid || i_pop);
    assign o_cmd_pop    = issue;
    assign is_clear_cmd = (i_cmd_data[CMD_W-1 -: ACT_W] == ACT_CLEAR);
    assign clr_last     = (r_clr_idx == SLOT_W'(NUM_BUCKETS - 1));

    // RAM write: zero rows during a clearing pass, updated row after an action
    assign ram_we    = (r_state == S_CLR) || ((r_state == S_EXEC) && upd);
    assign ram_waddr = (r_state == S_CLR) ? r_clr_idx : r_bucket;
    assign ram_wdata = (r_state == S_CLR) ? '0 : wrow;

    // Way search over the fetched bucket
    always_comb begin
        vrow     = row[DATA_W +: WAYS];
        hit      = 1'b0;
        has_free = 1'b0;
        hit_way  = '0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (vrow[w] && row[w*ENT_W + VAL_W +: HASH_W] == r_hash) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!vrow[w]) begin
                has_free = 1'b1;
                free_way = WAY_W'(w);
            end
        end
    end

    // Action on the bucket
    always_comb begin
        wrow     = row;
        upd      = 1'b0;
        n_vrow   = vrow;
        n_status = ST_FULL_CLR;
        n_vout   = '0;
        n_count  = r_count;
        case (t_action'(r_act))
            ACT_PUT: begin
                if (hit) begin
                    wrow[32'(hit_way)*ENT_W +: VAL_W] = r_val;
                    upd      = 1'b1;
                    n_status = ST_REPLACED;
                end else if (has_free) begin
                    wrow[32'(free_way)*ENT_W +: ENT_W] = {r_hash, r_val};
                    upd              = 1'b1;
                    n_vrow[free_way] = 1'b1;
                    n_count          = r_count + 1'b1;
                    n_status         = ST_INSERTED;
                end else begin
                    n_status = ST_FULL_CLR;
                end
            end
            ACT_GET: begin
                if (hit) begin
                    n_vout   = row[32'(hit_way)*ENT_W +: VAL_W];
                    n_status = ST_FOUND;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            ACT_REMOVE: begin
                if (hit) begin
                    n_vrow[hit_way] = 1'b0;
                    upd             = 1'b1;
                    n_count         = r_count - 1'b1;
                    n_status        = ST_REMOVED;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_count  = '0;
                n_status = ST_FULL_CLR;
            end
        endcase
        wrow[DATA_W +: WAYS] = n_vrow;
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (issue) n_state = is_clear_cmd ? S_CLR : S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            S_CLR:   if (clr_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Command latch and result payload
    always_ff @(posedge i_clk) begin
        if (issue) begin
            {r_act, r_hash, r_bucket, r_val} <= i_cmd_data;
        end
        if (r_state == S_EXEC) begin
            r_status <= n_status;
            r_vout   <= n_vout;
        end else if ((r_state == S_CLR) && clr_last && r_clr_reply) begin
            r_status <= ST_FULL_CLR;
            r_vout   <= '0;
        end
    end

    // Control state, clearing pass and entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_idx   <= '0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state <= n_state;
            if (issue && is_clear_cmd) begin
                r_clr_idx   <= '0;
                r_clr_reply <= 1'b1;
            end else if (r_state == S_CLR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (clr_last) begin
                    r_clr_reply <= 1'b0;
                end
            end
            if (r_state == S_EXEC) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if ((r_state == S_CLR) && clr_last) begin
                // The pass after reset gives no result
                if (r_clr_reply) begin
                    r_out_valid <= 1'b1;
                end
                r_count <= '0;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_status      = r_status;
    assign o_value_out   = r_vout;
    assign o_entry_count = r_count;

endmodule

// ===== design/hashed_key_value_table.sv =====
// Key/value table keyed by the djb2 hash of a byte-streamed key. Each push
// carries one key byte; the byte with key_last set also carries the action
// (put, get, remove, clear) and yields exactly one result on the output
// queue. Entries are matched on the 32-bit hash only, and each of the
// NUM_BUCKETS buckets holds up to WAYS entries. Key bytes are taken one per
// cycle while o_full is low. For a final byte the table stage reads the
// bucket row from the RAM, then compares and writes it back, and it takes
// no new command until it is through with the last one; a two-entry queue
// lets hashing run ahead. When NUM_BUCKETS is not a power of two, the
// bucket index takes three register steps (byte fold, reciprocal multiply,
// subtract) and the hashing side takes no new key byte until the command
// for a final byte has been pushed into the queue. A result waits in the
// output register until popped; the table stage starts a new action only
// when that register is free or is popped in the same cycle. Valid bits
// live in the bucket rows, so reset and clear each run a clearing pass over
// all NUM_BUCKETS rows, one row per cycle: no action runs until the pass
// after reset ends; a clear gives its result once its last row is cleared.
module hashed_key_value_table
    import kvt_pkg::*;
#(
    parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
    parameter int WAYS        = DEF_WAYS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [ACT_W-1:0]   i_action,
    input  logic [BYTE_W-1:0]  i_key_byte,
    input  logic               i_key_last,
    input  logic [VAL_W-1:0]   i_value,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [STAT_W-1:0]  o_status,
    output logic [VAL_W-1:0]   o_value_out,
    output logic [COUNT_W-1:0] o_entry_count
);

    localparam int SLOT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int CMD_W  = ACT_W + HASH_W + SLOT_W + VAL_W;

    logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
    logic [CMD_W-1:0] cmd_in, cmd_out;

    // Hashing side
    kvt_front #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .SLOT_W      (SLOT_W),
        .CMD_W       (CMD_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_action   (i_action),
        .i_key_byte (i_key_byte),
        .i_key_last (i_key_last),
        .i_value    (i_value),
        .o_cmd_push (cmd_push),
        .o_cmd_data (cmd_in),
        .i_cmd_full (cmd_full)
    );

    // Command queue
    kvt_fifo #(
        .WIDTH (CMD_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (cmd_out)
    );

    // Table side
    kvt_back #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .WAYS        (WAYS),
        .SLOT_W      (SLOT_W),
        .CMD_W       (CMD_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_empty   (cmd_empty),
        .i_cmd_data    (cmd_out),
        .o_cmd_pop     (cmd_pop),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_status      (o_status),
        .o_value_out   (o_value_out),
        .o_entry_count (o_entry_count)
    );

endmodule
